// File: rtl/core/lkv_pkg.sv
// ============================================================================
// lkv_pkg
// Shared types and constants of the LRU key-value cache.
// ============================================================================
package lkv_pkg;

  // Store geometry.
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 16;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int RANK_BITS  = IDX_BITS;
  localparam int CNT_BITS   = $clog2(ENTRIES + 1);

  // Capacity register.
  localparam int CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
  localparam int CMP_BITS = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;

  // Request kinds.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Input transaction payload.
  typedef struct packed {
    logic                  req_type;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value_in;
  } req_t;

  // Output transaction payload.
  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic do_look;
    logic do_upd;
  } cmd_t;

endpackage

// File: rtl/core/lkv_ctrl.sv
// ============================================================================
// lkv_ctrl
// Sequencer of the cache: accept, look up, update, and output handshake.
// ============================================================================
module lkv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lkv_pkg::cmd_t cmd_o
);
  import lkv_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o.load_req = 1'b0;
    cmd_o.do_look  = 1'b0;
    cmd_o.do_upd   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.do_look = 1'b1;
        state_d       = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          cmd_o.do_upd = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag: set by a finished update, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.do_upd) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/lkv_datapath.sv
// ============================================================================
// lkv_datapath
// Entry store, parallel key compare, recency ranks and result register.
// ============================================================================
module lkv_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lkv_pkg::cmd_t                 cmd_i,
  input  lkv_pkg::req_t                 req_i,
  input  logic                          cfg_we_i,
  input  logic [lkv_pkg::CAP_BITS-1:0]  cfg_wdata_i,
  output lkv_pkg::rsp_t                 rsp_o
);
  import lkv_pkg::*;

  // Control state of the store.
  logic [CAP_BITS-1:0]  cap_q;
  logic [ENTRIES-1:0]   valid_q, valid_d;
  logic [RANK_BITS-1:0] rank_q [ENTRIES];
  logic [RANK_BITS-1:0] rank_d [ENTRIES];
  logic [CNT_BITS-1:0]  count_q, count_d;

  // Payload storage.
  logic [KEY_BITS-1:0]   key_q   [ENTRIES];
  logic [VALUE_BITS-1:0] value_q [ENTRIES];

  // Transaction registers.
  req_t                 req_q;
  logic                 hit_q;
  logic [IDX_BITS-1:0]  hit_slot_q;
  logic [IDX_BITS-1:0]  slot_q;
  logic [RANK_BITS-1:0] old_rank_q;
  logic                 full_q;
  rsp_t                 rsp_q;

  // Lookup results.
  logic                 hit;
  logic [IDX_BITS-1:0]  hit_slot;
  logic [RANK_BITS-1:0] hit_rank;
  logic [IDX_BITS-1:0]  victim_slot;
  logic [IDX_BITS-1:0]  free_slot;
  logic [RANK_BITS-1:0] count_m1;
  logic [CMP_BITS-1:0]  cap_eff;
  logic                 full;

  // Update controls.
  logic                is_put;
  logic                ins;
  logic                touch;
  logic [IDX_BITS-1:0] tgt;

  // Capacity clamped to one through the number of entries.
  always_comb begin
    cap_eff = CMP_BITS'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CMP_BITS'(1);
    end else if (CMP_BITS'(cap_q) > CMP_BITS'(ENTRIES)) begin
      cap_eff = CMP_BITS'(ENTRIES);
    end
  end

  assign full     = CMP_BITS'(count_q) >= cap_eff;
  assign count_m1 = RANK_BITS'(count_q - CNT_BITS'(1));

  // Parallel key compare, hit encode, oldest entry and lowest free slot.
  always_comb begin
    hit         = 1'b0;
    hit_slot    = '0;
    hit_rank    = '0;
    victim_slot = '0;
    free_slot   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_q[i] && key_q[i] == req_q.key) begin
        hit      = 1'b1;
        hit_slot = hit_slot | IDX_BITS'(i);
        hit_rank = hit_rank | rank_q[i];
      end
      if (valid_q[i] && rank_q[i] == count_m1) begin
        victim_slot = victim_slot | IDX_BITS'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = IDX_BITS'(i);
      end
    end
  end

  assign is_put = (req_q.req_type == REQ_PUT);
  assign ins    = is_put && !hit_q;
  assign touch  = hit_q || ins;
  assign tgt    = hit_q ? hit_slot_q : slot_q;

  // Next valid bits, ranks and fill count.
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    count_d = count_q;
    if (cfg_we_i) begin
      valid_d = '0;
      count_d = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_d[i] = '0;
      end
    end else if (cmd_i.do_upd && touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && IDX_BITS'(i) != tgt && rank_q[i] < old_rank_q) begin
          rank_d[i] = rank_q[i] + RANK_BITS'(1);
        end
      end
      rank_d[tgt] = '0;
      if (ins) begin
        valid_d[tgt] = 1'b1;
        if (!full_q) begin
          count_d = count_q + CNT_BITS'(1);
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      valid_q <= '0;
      count_q <= '0;
      rank_q  <= '{default: '0};
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      valid_q <= valid_d;
      count_q <= count_d;
      rank_q  <= rank_d;
    end
  end

  // Transaction, lookup and result registers, plus entry payload writes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.do_look) begin
      hit_q      <= hit;
      hit_slot_q <= hit_slot;
      full_q     <= full;
      slot_q     <= full ? victim_slot : free_slot;
      old_rank_q <= hit ? hit_rank : (full ? count_m1 : RANK_BITS'(count_q));
    end
    if (cmd_i.do_upd) begin
      rsp_q.found      <= hit_q;
      rsp_q.read_value <= (!is_put && hit_q) ? value_q[hit_slot_q] : '0;
      if (is_put) begin
        value_q[tgt] <= req_q.value_in;
      end
      if (ins) begin
        key_q[tgt] <= req_q.key;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

// File: rtl/core/lru_key_value_cache.sv
// ============================================================================
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ============================================================================
// Usage:
//   Requests enter on the input channel (in_valid_i, in_stall_o, in_data_i)
//   as a get or a put with a key and a value. Each request yields exactly one
//   result transaction on the output channel (out_valid_o, out_stall_i,
//   out_data_o): found tells whether the key was present, read_value holds
//   the stored value on a get hit and zero otherwise.
//   A request passes through accept, lookup (parallel key compare over all
//   entries, recency rank select) and update (rank promotion, entry write,
//   result register load). A new request is not accepted until the update
//   of the one before it is done; the result is registered by the update.
//   The result register lets the next request be accepted while a result
//   waits; the update step holds while the receiver stalls a full register.
//   Reset empties the store and sets capacity to sixteen. Writing the
//   capacity register (cfg_we_i, cfg_wdata_i) also empties the store and
//   must happen only while the block is idle.
// ============================================================================
module lru_key_value_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lkv_pkg::req_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lkv_pkg::rsp_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lkv_pkg::CAP_BITS-1:0]  cfg_wdata_i
);
  import lkv_pkg::*;

  cmd_t cmd;

  // Sequencer.
  lkv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Store and result datapath.
  lkv_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (out_data_o)
  );

endmodule
